FILE: src/weighted_route_table_lookup_defines.svh
// Assertion macros for the weighted route table lookup block
`ifndef WEIGHTED_ROUTE_TABLE_LOOKUP_DEFINES_SVH
`define WEIGHTED_ROUTE_TABLE_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WRTL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define WRTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/wrtl_pkg.sv
// Shared constants and types of the weighted route table lookup block
package wrtl_pkg;

   localparam int NUM_LINKS   = 16;
   localparam int NUM_VNETS   = 4;
   localparam int DEST_BITS   = 64;
   localparam int WEIGHT_BITS = 16;

   localparam int LINK_W      = $clog2(NUM_LINKS);
   localparam int CNT_W       = $clog2(NUM_LINKS + 1);
   localparam int VNET_W      = 2;
   localparam int ADDR_W      = $clog2(NUM_VNETS * NUM_LINKS);
   localparam int WEIGHT_IN_W = 16;
   localparam int LFSR_W      = 16;
   localparam int STEP_W      = $clog2(LFSR_W + 1);

   localparam logic [LFSR_W-1:0] LFSR_RESET = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

   // Request codes
   localparam logic [1:0] REQ_LOOKUP     = 2'd0;
   localparam logic [1:0] REQ_WR_MASK    = 2'd1;
   localparam logic [1:0] REQ_WR_WEIGHT  = 2'd2;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int ACTIVE_W   = 5;
   localparam int ORDERED_W  = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LINKS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDERED_VNETS = 2'd1;

   // Modulo unit control and status
   typedef struct packed {
      logic              start;
      logic [LFSR_W-1:0] dividend;
      logic [CNT_W-1:0]  divisor;
   } mod_ctl_type;

   typedef struct packed {
      logic              done;
      logic [LINK_W-1:0] remainder;
   } mod_stat_type;

endpackage

FILE: src/wrtl_mask_ram.sv
// Route mask memory with per-entry valid bits and registered read
module wrtl_mask_ram
   import wrtl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [DEST_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [DEST_BITS-1:0] rd_data
);

   localparam int DEPTH = NUM_VNETS * NUM_LINKS;

   logic [DEST_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   logic [DEPTH-1:0]     valid_in;
   logic [DEST_BITS-1:0] rdata_ff;
   logic                 rvalid_ff;

   // Mark written entries
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   // Unwritten entries read as zero
   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

FILE: src/wrtl_mod_unit.sv
// Bit-serial restoring modulo: LFSR value modulo candidate count
module wrtl_mod_unit
   import wrtl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mod_ctl_type  ctl,
   output mod_stat_type stat
);

   logic [STEP_W-1:0] step_ff,   step_in;
   logic [LFSR_W-1:0] quot_ff,   quot_in;
   logic [CNT_W-1:0]  rem_ff,    rem_in;
   logic [CNT_W-1:0]  div_ff,    div_in;
   logic              done_ff,   done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   // Shift in one dividend bit and subtract when it fits
   always_comb begin
      trial   = {rem_ff, quot_ff[LFSR_W-1]};
      diff    = trial - {1'b0, div_ff};
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         step_in = STEP_W'(LFSR_W);
         quot_in = ctl.dividend;
         rem_in  = '0;
         div_in  = ctl.divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         quot_in = {quot_ff[LFSR_W-2:0], 1'b0};
         rem_in  = (trial >= {1'b0, div_ff}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff[LINK_W-1:0];

endmodule

FILE: src/weighted_route_table_lookup.sv
// Top level of the weighted route table lookup block
// Picks a router output link. A write item loads one route mask (per virtual
// network and link) or one link weight and is acknowledged with an all-zero
// result once the output register is free. A lookup item walks links 0 to
// min(active_links, 16)-1 one per cycle through the single read port of
// the route mask memory, keeping the running minimum weight, the tie count
// and a candidate bit vector in one shared compare unit. An unordered
// network with a match then takes LFSR mod count in a bit-serial modulo
// unit, and a walk over the candidate vector picks that candidate.
// The block takes one item at a time; a finished result waits in an output
// register while the next item is accepted. Reset clears the mask table at
// once through valid bits and the link weights directly, so no clearing
// pass is needed.
module weighted_route_table_lookup
   import wrtl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [VNET_W-1:0]      req_vnet,
   input  logic [LINK_W-1:0]      req_link_index,
   input  logic [DEST_BITS-1:0]   req_dest_mask,
   input  logic [WEIGHT_IN_W-1:0] req_weight,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LINK_W-1:0]      rsp_out_link,
   output logic                   rsp_no_route,
   output logic [CNT_W-1:0]       rsp_candidate_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "weighted_route_table_lookup_defines.svh"

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_EVAL = 6'b000100,
      ST_MOD  = 6'b001000,
      ST_SEL  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [VNET_W-1:0]       vnet_ff, vnet_in;
   logic [DEST_BITS-1:0]    dest_ff, dest_in;
   logic                    ordered_ff, ordered_in;
   logic [CNT_W-1:0]        links_ff, links_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [LINK_W-1:0]       rd_link_ff, rd_link_in;
   logic [WEIGHT_BITS-1:0]  best_ff, best_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [NUM_LINKS-1:0]    cand_ff, cand_in;
   logic [LINK_W-1:0]       pick_ff, pick_in;
   logic [LINK_W-1:0]       sel_ff, sel_in;
   logic [LINK_W-1:0]       res_link_ff, res_link_in;
   logic                    res_none_ff, res_none_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LINK_W-1:0]       rsp_link_ff, rsp_link_in;
   logic                    rsp_none_ff, rsp_none_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [LFSR_W-1:0]       lfsr_ff, lfsr_in;
   logic [ACTIVE_W-1:0]     active_links_ff, active_links_in;
   logic [ORDERED_W-1:0]    ordered_vnets_ff, ordered_vnets_in;
   logic [WEIGHT_BITS-1:0]  weight_ff [NUM_LINKS];
   logic [WEIGHT_BITS-1:0]  weight_in [NUM_LINKS];

   logic                    req_fire;
   logic                    mem_wr_en;
   logic [ADDR_W-1:0]       mem_wr_addr;
   logic                    mem_rd_en;
   logic [ADDR_W-1:0]       mem_rd_addr;
   logic [DEST_BITS-1:0]    mem_rd_data;
   logic                    hit;
   logic [WEIGHT_BITS-1:0]  cur_weight;
   logic [LFSR_W-1:0]       lfsr_step;
   mod_ctl_type             mod_ctl;
   mod_stat_type            mod_stat;

   wrtl_mask_ram u_mask_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (dest_in),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   wrtl_mod_unit u_mod_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (mod_ctl),
      .stat  (mod_stat)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_link        = rsp_link_ff;
   assign rsp_no_route        = rsp_none_ff;
   assign rsp_candidate_count = rsp_count_ff;

   // Galois step: shift right, fold taps in when a one drops out
   assign lfsr_step = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

   // Shared compare unit inputs for the link whose mask just came back
   assign hit        = |(dest_ff & mem_rd_data);
   assign cur_weight = weight_ff[rd_link_ff];

   // Register writes
   always_comb begin
      active_links_in  = active_links_ff;
      ordered_vnets_in = ordered_vnets_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ACTIVE_LINKS:  active_links_in  = csr_wdata[ACTIVE_W-1:0];
            CSR_ORDERED_VNETS: ordered_vnets_in = csr_wdata[ORDERED_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      vnet_in      = vnet_ff;
      dest_in      = dest_ff;
      ordered_in   = ordered_ff;
      links_in     = links_ff;
      idx_in       = idx_ff;
      rd_pend_in   = 1'b0;
      rd_link_in   = rd_link_ff;
      best_in      = best_ff;
      count_in     = count_ff;
      cand_in      = cand_ff;
      pick_in      = pick_ff;
      sel_in       = sel_ff;
      res_link_in  = res_link_ff;
      res_none_in  = res_none_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_link_in  = rsp_link_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_count_in = rsp_count_ff;
      lfsr_in      = lfsr_ff;
      weight_in    = weight_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ADDR_W'(ADDR_W'(req_vnet) * ADDR_W'(NUM_LINKS) + ADDR_W'(req_link_index));
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ADDR_W'(ADDR_W'(vnet_ff) * ADDR_W'(NUM_LINKS)
                             + ADDR_W'(idx_ff[LINK_W-1:0]));
      mod_ctl.start    = 1'b0;
      mod_ctl.dividend = lfsr_ff;
      mod_ctl.divisor  = count_ff;

      // Fold the returned link into minimum, tie count and candidate set
      if (rd_pend_ff && hit) begin
         if (count_ff == '0 || cur_weight < best_ff) begin
            best_in  = cur_weight;
            count_in = CNT_W'(1);
            cand_in  = NUM_LINKS'(1) << rd_link_ff;
         end else if (cur_weight == best_ff) begin
            count_in = count_ff + 1'b1;
            cand_in  = cand_ff | (NUM_LINKS'(1) << rd_link_ff);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               vnet_in     = req_vnet;
               dest_in     = req_dest_mask[DEST_BITS-1:0];
               count_in    = '0;
               cand_in     = '0;
               best_in     = '0;
               idx_in      = '0;
               res_link_in = '0;
               res_none_in = 1'b0;
               state_in    = ST_DONE;
               unique case (req_type)
                  REQ_LOOKUP: begin
                     ordered_in = ordered_vnets_ff[req_vnet];
                     if (32'(req_vnet) >= NUM_VNETS) begin
                        links_in = '0;
                     end else if (32'(active_links_ff) > NUM_LINKS) begin
                        links_in = CNT_W'(NUM_LINKS);
                     end else begin
                        links_in = CNT_W'(active_links_ff);
                     end
                     state_in = ST_SCAN;
                  end
                  REQ_WR_MASK: begin
                     mem_wr_en = (32'(req_link_index) < NUM_LINKS)
                                 && (32'(req_vnet) < NUM_VNETS);
                  end
                  REQ_WR_WEIGHT: begin
                     if (32'(req_link_index) < NUM_LINKS) begin
                        weight_in[req_link_index] = req_weight[WEIGHT_BITS-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // Issue one mask read per cycle, then drain the last one
            if (idx_ff < links_ff) begin
               mem_rd_en  = 1'b1;
               rd_pend_in = 1'b1;
               rd_link_in = idx_ff[LINK_W-1:0];
               idx_in     = idx_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!ordered_ff) begin
               lfsr_in = lfsr_step;
            end
            pick_in = '0;
            sel_in  = '0;
            if (count_ff == '0) begin
               res_none_in = 1'b1;
               state_in    = ST_DONE;
            end else if (ordered_ff) begin
               state_in = ST_SEL;
            end else begin
               mod_ctl.start = 1'b1;
               state_in      = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_stat.done) begin
               pick_in  = mod_stat.remainder;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            // Walk the candidate set, skipping pick candidates
            if (cand_ff[sel_ff]) begin
               if (pick_ff == '0) begin
                  res_link_in = sel_ff;
                  state_in    = ST_DONE;
               end else begin
                  pick_in = pick_ff - 1'b1;
               end
            end
            sel_in = sel_ff + 1'b1;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_link_in  = res_link_ff;
               rsp_none_in  = res_none_ff;
               rsp_count_in = res_none_ff ? '0 : count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rd_pend_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         lfsr_ff          <= LFSR_RESET;
         active_links_ff  <= '0;
         ordered_vnets_ff <= '0;
         for (int i = 0; i < NUM_LINKS; i++) begin
            weight_ff[i] <= '0;
         end
      end else begin
         state_ff         <= state_in;
         rd_pend_ff       <= rd_pend_in;
         rsp_valid_ff     <= rsp_valid_in;
         lfsr_ff          <= lfsr_in;
         active_links_ff  <= active_links_in;
         ordered_vnets_ff <= ordered_vnets_in;
         weight_ff        <= weight_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      vnet_ff      <= vnet_in;
      dest_ff      <= dest_in;
      ordered_ff   <= ordered_in;
      links_ff     <= links_in;
      idx_ff       <= idx_in;
      rd_link_ff   <= rd_link_in;
      best_ff      <= best_in;
      count_ff     <= count_in;
      cand_ff      <= cand_in;
      pick_ff      <= pick_in;
      sel_ff       <= sel_in;
      res_link_ff  <= res_link_in;
      res_none_ff  <= res_none_in;
      rsp_link_ff  <= rsp_link_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Checks
   `WRTL_ASSERT_NOW(a_lfsr_nonzero, clock, reset, 1'b1, lfsr_ff != '0, "lfsr reached zero")
   `WRTL_ASSERT_NOW(a_mod_done_in_mod, clock, reset, mod_stat.done, state_ff == ST_MOD,
                    "modulo done outside wait")
   `WRTL_ASSERT_NOW(a_sel_has_cand, clock, reset, state_ff == ST_SEL, cand_ff != '0,
                    "select walk with no candidate")
   `WRTL_ASSERT_NEXT(a_no_route_zero, clock, reset,
                     state_ff == ST_DONE && res_none_ff && (!rsp_valid_ff || rsp_ready),
                     rsp_count_ff == '0 && rsp_link_ff == '0,
                     "no route result carries link or count")

endmodule
